>>> design/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and the code function of the LBP tile stream.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 10;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [CFG_W-1:0] RST_TILE_SIZE    = 11'd48;
    localparam logic [CFG_W-1:0] MIN_DIM          = 11'd3;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_TILE_SIZE    = 2'd2
    } reg_idx_t;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef pix_t [8:0]         win_t;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [CFG_W-1:0] tile_size;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        win_t   win;
        coord_t out_col;
        coord_t out_row;
        coord_t tile_col;
        coord_t tile_row;
        logic   frame_end;
    } entry_t;

    // window index is row * 3 + column, centre at 4
    function automatic pix_t lbp_pattern(input win_t w);
        pix_t code;
        code[0] = w[4] < w[1];
        code[1] = w[4] < w[2];
        code[2] = w[4] < w[5];
        code[3] = w[4] < w[8];
        code[4] = w[4] < w[7];
        code[5] = w[4] < w[6];
        code[6] = w[4] < w[3];
        code[7] = w[4] < w[0];
        return code;
    endfunction

endpackage

>>> design/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram
// Simple dual-port RAM, one write and one registered read-first read port.
// ----------------------------------------------------------------------------
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> design/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Pixel intake: position and tile tracking, line buffers, 3x3 window.
// ----------------------------------------------------------------------------
module lbp_front
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  pix_t              pixel,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [QCNT_W-1:0] q_level,
    output logic              q_push,
    output entry_t            q_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]    w_last;
    logic [RW-1:0]    h_last;
    logic [CFG_W-1:0] ts_eff;

    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    tc_reg, tc_next;
    logic [CFG_W-1:0] tcp_reg, tcp_next;
    logic [RW-1:0]    tr_reg, tr_next;
    logic [CFG_W-1:0] trp_reg, trp_next;

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic             interior;

    logic             s1_valid_reg;
    logic             s1_int_reg;
    logic [CW-1:0]    s1_col_reg;
    pix_t             s1_pix_reg;
    coord_t           s1_oc_reg;
    coord_t           s1_or_reg;
    coord_t           s1_tc_reg;
    coord_t           s1_tr_reg;
    logic             s1_end_reg;

    pix_t             top_q;
    pix_t             mid_q;
    win_t             win_reg;
    win_t             win_next;

    always_comb
    begin
        if (cfg.frame_width < MIN_DIM)
            w_last = CW'(2);
        else if (32'(cfg.frame_width) > MAX_WIDTH)
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(cfg.frame_width - 11'd1);

        if (cfg.frame_height < MIN_DIM)
            h_last = RW'(2);
        else if (32'(cfg.frame_height) > MAX_HEIGHT)
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(cfg.frame_height - 11'd1);

        ts_eff = (cfg.tile_size == '0) ? CFG_W'(1) : cfg.tile_size;
    end

    assign in_ready = (32'(q_level) + 32'(s1_valid_reg && s1_int_reg)) < QDEPTH;
    assign accept   = in_valid && in_ready;
    assign last_col = (col_reg == w_last);
    assign last_row = (row_reg == h_last);
    assign interior = (row_reg >= RW'(2)) && (col_reg >= CW'(2));

    always_comb
    begin
        col_next = last_col ? '0 : col_reg + CW'(1);
        row_next = row_reg;
        if (last_col)
            row_next = last_row ? '0 : row_reg + RW'(1);

        tc_next  = tc_reg;
        tcp_next = tcp_reg;
        if (last_col)
        begin
            tc_next  = '0;
            tcp_next = '0;
        end
        else if (col_reg >= CW'(2))
        begin
            if (tcp_reg + CFG_W'(1) == ts_eff)
            begin
                tcp_next = '0;
                tc_next  = tc_reg + CW'(1);
            end
            else
                tcp_next = tcp_reg + CFG_W'(1);
        end

        tr_next  = tr_reg;
        trp_next = trp_reg;
        if (last_col && (row_reg >= RW'(2)))
        begin
            if (last_row)
            begin
                tr_next  = '0;
                trp_next = '0;
            end
            else if (trp_reg + CFG_W'(1) == ts_eff)
            begin
                trp_next = '0;
                tr_next  = tr_reg + RW'(1);
            end
            else
                trp_next = trp_reg + CFG_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            tc_reg       <= '0;
            tcp_reg      <= '0;
            tr_reg       <= '0;
            trp_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg.restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                tc_reg  <= '0;
                tcp_reg <= '0;
                tr_reg  <= '0;
                trp_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                tc_reg  <= tc_next;
                tcp_reg <= tcp_next;
                tr_reg  <= tr_next;
                trp_reg <= trp_next;
            end
            if (s1_valid_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_int_reg <= interior;
            s1_col_reg <= col_reg;
            s1_pix_reg <= pixel;
            s1_oc_reg  <= COORD_W'(col_reg - CW'(2));
            s1_or_reg  <= COORD_W'(row_reg - RW'(2));
            s1_tc_reg  <= COORD_W'(tc_reg);
            s1_tr_reg  <= COORD_W'(tr_reg);
            s1_end_reg <= last_col && last_row;
        end
    end

    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_line (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pixel),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_q)
    );

    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_top_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_q),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top_q)
    );

    // shift window left, new column enters on the right
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3 + 1];
            win_next[i*3 + 1] = win_reg[i*3 + 2];
        end
        win_next[2] = top_q;
        win_next[5] = mid_q;
        win_next[8] = s1_pix_reg;
    end

    assign q_push             = s1_valid_reg && s1_int_reg;
    assign q_entry.win        = win_next;
    assign q_entry.out_col    = s1_oc_reg;
    assign q_entry.out_row    = s1_or_reg;
    assign q_entry.tile_col   = s1_tc_reg;
    assign q_entry.tile_row   = s1_tr_reg;
    assign q_entry.frame_end  = s1_end_reg;

endmodule

>>> design/lbp_queue.sv
// ----------------------------------------------------------------------------
// lbp_queue
// Small register FIFO between window intake and code output.
// ----------------------------------------------------------------------------
module lbp_queue
    import lbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  entry_t            din,
    input  logic              pop,
    output entry_t            dout,
    output logic              not_empty,
    output logic [QCNT_W-1:0] level
);

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign level     = count_reg;
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

>>> design/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Code compare and output register.
// ----------------------------------------------------------------------------
module lbp_back
    import lbp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  entry_t q_head,
    output logic   q_pop,
    output logic   out_valid,
    input  logic   out_ready,
    output pix_t   lbp_code,
    output coord_t out_col,
    output coord_t out_row,
    output coord_t tile_col,
    output coord_t tile_row,
    output logic   frame_end
);

    logic   out_valid_reg;
    logic   load;
    pix_t   code_reg;
    coord_t col_reg;
    coord_t row_reg;
    coord_t tcol_reg;
    coord_t trow_reg;
    logic   end_reg;

    assign load  = !out_valid_reg || out_ready;
    assign q_pop = q_valid && load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            code_reg <= lbp_pattern(q_head.win);
            col_reg  <= q_head.out_col;
            row_reg  <= q_head.out_row;
            tcol_reg <= q_head.tile_col;
            trow_reg <= q_head.tile_row;
            end_reg  <= q_head.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign lbp_code  = code_reg;
    assign out_col   = col_reg;
    assign out_row   = row_reg;
    assign tile_col  = tcol_reg;
    assign tile_row  = trow_reg;
    assign frame_end = end_reg;

endmodule

>>> design/lbp_code_tile_stream_top.sv
// ----------------------------------------------------------------------------
// lbp_code_tile_stream_top
// 3x3 local binary pattern codes with interior and tile coordinates.
//
//   channel  | signals                               | transfer when
//   ---------+---------------------------------------+------------------------
//   pixel in | in_valid, in_ready, pixel             | in_valid && in_ready
//   code out | out_valid, out_ready, lbp_code, ...   | out_valid && out_ready
//   config   | psel, penable, pwrite, paddr, pwdata  | psel && penable && pwrite
//
// One pixel per clock while in_ready is high; codes pass a queue and output register.
// Rate is set by the line buffer RAMs: one read and one write per line a cycle.
// Reset loads the default frame size and tile size and restarts at row 0;
// line buffers are not cleared, the first two rows fill them.
// A four-entry queue and the output register take up output stalls;
// in_ready drops when the queue and the in-flight window would fill it.
// ----------------------------------------------------------------------------
module lbp_code_tile_stream_top
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  pix_t              pixel,
    output logic              out_valid,
    input  logic              out_ready,
    output pix_t              lbp_code,
    output coord_t            out_col,
    output coord_t            out_row,
    output coord_t            tile_col,
    output coord_t            tile_row,
    output logic              frame_end
);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [CFG_W-1:0]  tile_reg;
    logic              wr_en;
    logic              wr_hit;
    reg_idx_t          idx;
    cfg_t              cfg;

    logic [QCNT_W-1:0] q_level;
    logic              q_push;
    entry_t            q_entry;
    logic              q_pop;
    logic              q_valid;
    entry_t            q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:  wr_hit = wr_en;
            REG_FRAME_HEIGHT: wr_hit = wr_en;
            REG_TILE_SIZE:    wr_hit = wr_en;
            default:          wr_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(height_reg);
            REG_TILE_SIZE:    prdata = DATA_W'(tile_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            tile_reg   <= RST_TILE_SIZE;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_TILE_SIZE:    tile_reg   <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.frame_width  = width_reg;
    assign cfg.frame_height = height_reg;
    assign cfg.tile_size    = tile_reg;
    assign cfg.restart      = wr_hit;

    lbp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pixel    (pixel),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_level  (q_level),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    lbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_entry),
        .pop       (q_pop),
        .dout      (q_head),
        .not_empty (q_valid),
        .level     (q_level)
    );

    lbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .lbp_code  (lbp_code),
        .out_col   (out_col),
        .out_row   (out_row),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .frame_end (frame_end)
    );

endmodule

>>> design/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks on the code output and the configuration port.
// ----------------------------------------------------------------------------
module lbp_checker
    import lbp_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pready,
    input logic   out_valid,
    input logic   out_ready,
    input pix_t   lbp_code,
    input coord_t out_col,
    input coord_t out_row,
    input coord_t tile_col,
    input coord_t tile_row,
    input logic   frame_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lbp_code) && $stable(out_col)
            && $stable(out_row) && $stable(tile_col) && $stable(tile_row)
            && $stable(frame_end))
        else $error("output changed while stalled");

    a_tile_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tile_col <= out_col) && (tile_row <= out_row))
        else $error("tile index above coordinate");

    a_tile_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_col == '0 || out_row == '0) |->
            (out_col != '0 || tile_col == '0) && (out_row != '0 || tile_row == '0))
        else $error("tile index nonzero at origin");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind lbp_code_tile_stream_top lbp_checker u_lbp_checker (.*);
